// ===== src/rgb_gamma_interpolated_lut_unit_macros.svh =====
// Assertion macros shared by the checker of the gamma curve unit.
// Every macro samples on the rising edge of i_clk in the module that uses it.
`ifndef RGB_GAMMA_INTERPOLATED_LUT_UNIT_MACROS_SVH
`define RGB_GAMMA_INTERPOLATED_LUT_UNIT_MACROS_SVH

// A condition that must hold in the same cycle, outside reset.
`define RGIL_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger, outside reset.
`define RGIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// A consequence in the cycle after its trigger, checked during reset as well.
`define RGIL_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rgil_pkg.sv =====
// Package of the gamma curve unit: widths, register indexes and transaction types.
// Used by every module of the block except rgil_ram; depends on nothing else.
`default_nettype none

package rgil_pkg;

    // Curve table depth and the widths that follow from it.
    localparam int CURVE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(CURVE_DEPTH);

    // Field widths of the transactions.
    localparam int COLOR_W = 16;
    localparam int ENTRY_W = 17;
    localparam int IDX_W   = 8;

    // Configuration register widths.
    localparam int PC_W       = 9;
    localparam int BITS_W     = 5;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Datapath widths.
    localparam int PROD_W  = COLOR_W + ADDR_W;
    localparam int V_W     = ENTRY_W + COLOR_W;
    localparam int W_W     = V_W + COLOR_W;
    localparam int SHIFT_W = 6;

    // Reset values of the configuration registers.
    localparam int PC_RESET   = 256;
    localparam int BITS_RESET = 12;
    localparam logic [ADDR_W-1:0] NM1_RESET =
        ADDR_W'(((PC_RESET > CURVE_DEPTH) ? CURVE_DEPTH : PC_RESET) - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT = 2'd0,
        CFG_INPUT_BITS  = 2'd1,
        CFG_OUTPUT_BITS = 2'd2
    } t_cfg_reg;

    // Input transaction: a pixel or one curve table write.
    typedef struct packed {
        logic               func;
        logic [COLOR_W-1:0] blue_in;
        logic [COLOR_W-1:0] green_in;
        logic [COLOR_W-1:0] red_in;
        logic [IDX_W-1:0]   entry_index;
        logic [ENTRY_W-1:0] entry_value;
    } t_in_item;

    // Output transaction: one corrected pixel.
    typedef struct packed {
        logic [COLOR_W-1:0] blue_out;
        logic [COLOR_W-1:0] green_out;
        logic [COLOR_W-1:0] red_out;
    } t_out_item;

    // Effective configuration, already saturated into range.
    typedef struct packed {
        logic [ADDR_W-1:0] nm1;
        logic [BITS_W-1:0] ib;
        logic [BITS_W-1:0] ob;
    } t_cfg;

    // Load enables of the pipeline registers, one per stage.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic so;
    } t_stage_en;

    // Curve table write port.
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } t_wr;

    // Point count clamped into 2..CURVE_DEPTH, returned minus one.
    function automatic logic [ADDR_W-1:0] f_point_nm1(input logic [PC_W-1:0] v);
        logic [ADDR_W-1:0] r;
        if (v < PC_W'(2)) begin
            r = ADDR_W'(1);
        end else if (32'(v) > CURVE_DEPTH) begin
            r = ADDR_W'(CURVE_DEPTH - 1);
        end else begin
            r = ADDR_W'(v - PC_W'(1));
        end
        return r;
    endfunction

    // Bit depth saturated into 1..16.
    function automatic logic [BITS_W-1:0] f_sat_bits(input logic [BITS_W-1:0] b);
        logic [BITS_W-1:0] r;
        if (b < BITS_W'(1)) begin
            r = BITS_W'(1);
        end else if (b > BITS_W'(COLOR_W)) begin
            r = BITS_W'(COLOR_W);
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/rgil_ram.sv =====
// Generic RAM with one write port and two registered read ports.
// Stand-alone; holds one copy of the curve table.
`default_nettype none

module rgil_ram #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 17
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [DATA_W-1:0]        o_rdata_a,
    output logic      [DATA_W-1:0]        o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Both read ports; the data holds while the reader is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== src/rgil_lane.sv =====
// One colour lane of the gamma curve unit: scaling, table lookup, interpolation, output scaling.
// Depends on rgil_pkg and rgil_ram; the lane keeps its own copy of the curve table.
`default_nettype none

module rgil_lane (
    input  wire logic                            i_clk,
    input  wire rgil_pkg::t_stage_en             i_en,
    input  wire rgil_pkg::t_cfg                  i_cfg,
    input  wire rgil_pkg::t_wr                   i_wr,
    input  wire logic [rgil_pkg::COLOR_W-1:0]    i_color,
    output logic      [rgil_pkg::COLOR_W-1:0]    o_color
);

    logic [rgil_pkg::COLOR_W-1:0]  r_color;
    logic [rgil_pkg::COLOR_W-1:0]  in_max;
    logic [rgil_pkg::COLOR_W-1:0]  omax;
    logic [rgil_pkg::COLOR_W-1:0]  sat;
    logic [rgil_pkg::PROD_W-1:0]   r_prod;
    logic [rgil_pkg::PROD_W-1:0]   seg_full;
    logic [rgil_pkg::ADDR_W-1:0]   seg_max;
    logic [rgil_pkg::ADDR_W-1:0]   seg;
    logic [rgil_pkg::ADDR_W-1:0]   seg_next;
    logic [rgil_pkg::COLOR_W-1:0]  frac;
    logic [rgil_pkg::COLOR_W-1:0]  r_frac;
    logic [rgil_pkg::ENTRY_W-1:0]  c0;
    logic [rgil_pkg::ENTRY_W-1:0]  c1;
    logic signed [rgil_pkg::ENTRY_W:0]  diff;
    logic signed [rgil_pkg::V_W+1:0]    delta;
    logic [rgil_pkg::V_W-1:0]      base;
    logic signed [rgil_pkg::V_W+1:0]    sum;
    logic [rgil_pkg::V_W-1:0]      r_v;
    logic [rgil_pkg::W_W-1:0]      w;
    logic [rgil_pkg::W_W-1:0]      r_w;
    logic [rgil_pkg::W_W-1:0]      y_full;
    logic [rgil_pkg::COLOR_W-1:0]  y;
    logic [rgil_pkg::COLOR_W-1:0]  r_y;

    // Full-scale input and output codes for the configured bit depths.
    assign in_max = rgil_pkg::COLOR_W'(({{rgil_pkg::COLOR_W{1'b0}}, 1'b1} << i_cfg.ib) - 1'b1);
    assign omax   = rgil_pkg::COLOR_W'(({{rgil_pkg::COLOR_W{1'b0}}, 1'b1} << i_cfg.ob) - 1'b1);

    // Stage 1: input component register.
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_color <= i_color;
        end
    end

    // Stage 2: saturate the component and scale it by the segment count.
    assign sat = (r_color > in_max) ? in_max : r_color;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod <= rgil_pkg::PROD_W'(sat) * rgil_pkg::PROD_W'(i_cfg.nm1);
        end
    end

    // Split the scaled value into segment and fraction and look up both end points.
    assign seg_full = r_prod >> i_cfg.ib;
    assign seg_max  = i_cfg.nm1 - 1'b1;
    assign seg      = (seg_full > rgil_pkg::PROD_W'(seg_max)) ? seg_max
                                                             : seg_full[rgil_pkg::ADDR_W-1:0];
    assign seg_next = seg + 1'b1;
    assign frac     = r_prod[rgil_pkg::COLOR_W-1:0] & in_max;

    rgil_ram #(
        .DEPTH  (rgil_pkg::CURVE_DEPTH),
        .DATA_W (rgil_pkg::ENTRY_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_wr.en),
        .i_waddr   (i_wr.addr),
        .i_wdata   (i_wr.data),
        .i_re      (i_en.s3),
        .i_raddr_a (seg),
        .i_raddr_b (seg_next),
        .o_rdata_a (c0),
        .o_rdata_b (c1)
    );

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_frac <= frac;
        end
    end

    // Stage 4: linear interpolation as c0 * 2^ib + (c1 - c0) * frac, never negative.
    assign diff  = $signed({1'b0, c1}) - $signed({1'b0, c0});
    assign delta = diff * $signed({1'b0, r_frac});
    assign base  = {{rgil_pkg::COLOR_W{1'b0}}, c0} << i_cfg.ib;
    assign sum   = $signed({2'b00, base}) + delta;

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_v <= sum[rgil_pkg::V_W-1:0];
        end
    end

    // Stage 5: multiply by the output full scale, 2^ob - 1, as a shift and subtract.
    assign w = ({{rgil_pkg::COLOR_W{1'b0}}, r_v} << i_cfg.ob)
             - {{rgil_pkg::COLOR_W{1'b0}}, r_v};

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_w <= w;
        end
    end

    // Output stage: drop the fraction bits and clip to the output full scale.
    assign y_full = r_w >> (rgil_pkg::SHIFT_W'(i_cfg.ib) + rgil_pkg::SHIFT_W'(rgil_pkg::COLOR_W));
    assign y      = (y_full > rgil_pkg::W_W'(omax)) ? omax : y_full[rgil_pkg::COLOR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en.so) begin
            r_y <= y;
        end
    end

    assign o_color = r_y;

endmodule

`default_nettype wire

// ===== src/rgb_gamma_interpolated_lut_unit.sv =====
// Top level of the gamma curve unit: handshakes, configuration registers, pipeline control.
// Depends on rgil_pkg and rgil_lane (one lane per colour component).
//
// The unit takes one transaction per clock when not stalled and applies one piecewise-linear
// gamma curve to the blue, green and red components of each pixel. Each lane has a
// six-register pipeline, and a steady stream runs at one pixel per clock without output
// stalls. The two curve points of a segment come from a two-read-port copy of the table held
// in each lane, so all six lookups of a pixel happen in the same cycle. A table write travels
// through the first two stages and updates all three copies as it leaves the second, in stream
// order with the pixels around it; it gives no result. Stalls are absorbed stage by stage, so
// inputs are still taken while a finished pixel waits at the output if an earlier stage is
// empty. Table contents are undefined after reset and must be written before use. Configuration
// writes are accepted at any time but should only be made while the unit is idle.
`default_nettype none

module rgb_gamma_interpolated_lut_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input transactions.
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire rgil_pkg::t_in_item                  i_data,
    // Output transactions.
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output rgil_pkg::t_out_item                      o_data,
    // Configuration writes.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [rgil_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [rgil_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [rgil_pkg::ADDR_W-1:0] r_nm1;
    logic [rgil_pkg::BITS_W-1:0] r_ib;
    logic [rgil_pkg::BITS_W-1:0] r_ob;
    rgil_pkg::t_cfg              cfg;
    rgil_pkg::t_stage_en         en;
    rgil_pkg::t_wr               wr;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic r_v5;
    logic r_vo;

    logic                         r_func1;
    logic [rgil_pkg::IDX_W-1:0]   r_idx1;
    logic [rgil_pkg::ENTRY_W-1:0] r_val1;
    logic                         r_func2;
    logic [rgil_pkg::IDX_W-1:0]   r_idx2;
    logic [rgil_pkg::ENTRY_W-1:0] r_val2;

    // Configuration registers hold values already saturated into range.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm1 <= rgil_pkg::NM1_RESET;
            r_ib  <= rgil_pkg::BITS_W'(rgil_pkg::BITS_RESET);
            r_ob  <= rgil_pkg::BITS_W'(rgil_pkg::BITS_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rgil_pkg::CFG_POINT_COUNT: begin
                    r_nm1 <= rgil_pkg::f_point_nm1(i_cfg_data[rgil_pkg::PC_W-1:0]);
                end
                rgil_pkg::CFG_INPUT_BITS: begin
                    r_ib <= rgil_pkg::f_sat_bits(i_cfg_data[rgil_pkg::BITS_W-1:0]);
                end
                rgil_pkg::CFG_OUTPUT_BITS: begin
                    r_ob <= rgil_pkg::f_sat_bits(i_cfg_data[rgil_pkg::BITS_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.nm1 = r_nm1;
    assign cfg.ib  = r_ib;
    assign cfg.ob  = r_ob;

    // A stage may load when it is empty or when the stage after it loads as well.
    always_comb begin
        en.so = !r_vo || !i_stall;
        en.s5 = !r_v5 || en.so;
        en.s4 = !r_v4 || en.s5;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign o_stall = !en.s1;

    // Valid bits; a table write drops out of the pipeline after stage 2.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= i_valid;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2 && !r_func2;
            end
            if (en.s4) begin
                r_v4 <= r_v3;
            end
            if (en.s5) begin
                r_v5 <= r_v4;
            end
            if (en.so) begin
                r_vo <= r_v5;
            end
        end
    end

    // Function and table write fields for the first two stages.
    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_func1 <= i_data.func;
            r_idx1  <= i_data.entry_index;
            r_val1  <= i_data.entry_value;
        end
        if (en.s2) begin
            r_func2 <= r_func1;
            r_idx2  <= r_idx1;
            r_val2  <= r_val1;
        end
    end

    // Table write as the transaction leaves stage 2; indexes past the table are dropped.
    assign wr.en   = r_v2 && r_func2 && en.s3 && (32'(r_idx2) < rgil_pkg::CURVE_DEPTH);
    assign wr.addr = rgil_pkg::ADDR_W'(r_idx2);
    assign wr.data = r_val2;

    // One lane per colour component.
    rgil_lane u_blue (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_wr    (wr),
        .i_color (i_data.blue_in),
        .o_color (o_data.blue_out)
    );

    rgil_lane u_green (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_wr    (wr),
        .i_color (i_data.green_in),
        .o_color (o_data.green_out)
    );

    rgil_lane u_red (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (cfg),
        .i_wr    (wr),
        .i_color (i_data.red_in),
        .o_color (o_data.red_out)
    );

    assign o_valid = r_vo;

endmodule

`default_nettype wire

// ===== src/rgil_checker.sv =====
// Port-level checker of the gamma curve unit, bound to the top level.
// Depends on rgil_pkg and the assertion macros header.
`default_nettype none

`include "rgb_gamma_interpolated_lut_unit_macros.svh"

module rgil_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_valid,
    input wire logic                            o_stall,
    input wire rgil_pkg::t_in_item              i_data,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire rgil_pkg::t_out_item             o_data,
    input wire logic                            i_cfg_valid,
    input wire logic                            o_cfg_ready,
    input wire logic [rgil_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [rgil_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // A result being held back stays offered.
    `RGIL_ASSERT_NEXT(a_out_valid_held, o_valid && i_stall, o_valid, "output valid dropped while stalled")

    // A result being held back keeps its value.
    `RGIL_ASSERT_NEXT(a_out_data_held, o_valid && i_stall, $stable(o_data), "output data changed while stalled")

    // Reset empties the pipeline.
    `RGIL_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_valid, "output valid after reset")

    // With the output empty or draining, nothing holds back the input.
    `RGIL_ASSERT_NOW(a_no_idle_stall, (!o_valid || !i_stall) |-> !o_stall, "input stalled while the output drains")

endmodule

bind rgb_gamma_interpolated_lut_unit rgil_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for rgb_gamma_interpolated_lut_unit: curve loading, corner pixels,
// clipping and a long random stream, each pixel checked against a predicted corrected pixel.
// Depends on rgil_pkg and the RTL of the unit; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes carried in the func field of an input transaction.
    localparam logic FUNC_PIXEL       = 1'b0;
    localparam logic FUNC_TABLE_WRITE = 1'b1;

    // Pipeline depth, cycles allowed to settle after the last pixel, and watchdog limit.
    localparam int PIPE_LATENCY  = 6;
    localparam int SETTLE_CYCLES = 2 * PIPE_LATENCY;
    localparam int IDLE_LIMIT    = 2000;

    // Receiver behaviour, changed at random intervals.
    typedef enum logic [1:0] {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_BURSTY
    } t_rx_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    rgil_pkg::t_in_item   i_data      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    rgil_pkg::t_out_item  o_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [rgil_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [rgil_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Shadow of the curve table and of the raw configuration registers.
    logic [rgil_pkg::ENTRY_W-1:0] curve_pts [rgil_pkg::CURVE_DEPTH];
    logic [rgil_pkg::PC_W-1:0]    cfg_point_count = 9'd256;
    logic [rgil_pkg::BITS_W-1:0]  cfg_input_bits  = 5'd12;
    logic [rgil_pkg::BITS_W-1:0]  cfg_output_bits = 5'd12;

    // Corrected pixels still owed by the unit, oldest first.
    rgil_pkg::t_out_item pending_pixels [$];

    int       fault_count = 0;
    int       burst_left  = 0;
    bit       gaps_enabled = 1'b1;
    t_rx_mode rx_mode     = RX_FLOW;
    int       rx_mode_left = 0;
    int       rx_run_left  = 0;
    bit       rx_run_stalled = 1'b0;
    rgil_pkg::t_out_item want_px;

    rgb_gamma_interpolated_lut_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running 100 MHz clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bit depth as the unit uses it, saturated into 1..16.
    function automatic int unsigned eff_bits(input logic [rgil_pkg::BITS_W-1:0] b);
        int unsigned r;
        r = b;
        if (r < 1) r = 1;
        if (r > rgil_pkg::COLOR_W) r = rgil_pkg::COLOR_W;
        return r;
    endfunction

    // One colour component through the interpolated curve.
    function automatic logic [rgil_pkg::COLOR_W-1:0] eval_component(
            input logic [rgil_pkg::COLOR_W-1:0] color,
            input int unsigned n,
            input int unsigned ib,
            input int unsigned ob);
        bit [63:0] in_max, out_max, c, product, seg, frac, v, y;
        in_max  = (64'd1 << ib) - 64'd1;
        out_max = (64'd1 << ob) - 64'd1;
        c = color;
        if (c > in_max) c = in_max;
        product = c * 64'(n - 1);
        seg  = product >> ib;
        frac = product & in_max;
        if (seg > 64'(n - 2)) seg = 64'(n - 2);
        v = 64'(curve_pts[seg]) * ((64'd1 << ib) - frac) + 64'(curve_pts[seg + 1]) * frac;
        y = (out_max * v) >> (ib + 16);
        if (y > out_max) y = out_max;
        return y[rgil_pkg::COLOR_W-1:0];
    endfunction

    // Corrected pixel for the current configuration and table contents.
    function automatic rgil_pkg::t_out_item eval_pixel(input rgil_pkg::t_in_item px);
        rgil_pkg::t_out_item r;
        int unsigned n, ib, ob;
        n = cfg_point_count;
        if (n < 2) n = 2;
        if (n > rgil_pkg::CURVE_DEPTH) n = rgil_pkg::CURVE_DEPTH;
        ib = eff_bits(cfg_input_bits);
        ob = eff_bits(cfg_output_bits);
        r.blue_out  = eval_component(px.blue_in, n, ib, ob);
        r.green_out = eval_component(px.green_in, n, ib, ob);
        r.red_out   = eval_component(px.red_in, n, ib, ob);
        return r;
    endfunction

    // Pixel transaction; the unused table fields carry random bits.
    function automatic rgil_pkg::t_in_item make_pixel(input logic [rgil_pkg::COLOR_W-1:0] b,
                                                      input logic [rgil_pkg::COLOR_W-1:0] g,
                                                      input logic [rgil_pkg::COLOR_W-1:0] r);
        rgil_pkg::t_in_item it;
        it.func        = FUNC_PIXEL;
        it.blue_in     = b;
        it.green_in    = g;
        it.red_in      = r;
        it.entry_index = rgil_pkg::IDX_W'($urandom);
        it.entry_value = rgil_pkg::ENTRY_W'($urandom);
        return it;
    endfunction

    // Table write transaction; the unused colour fields carry random bits.
    function automatic rgil_pkg::t_in_item make_write(input logic [rgil_pkg::IDX_W-1:0] idx,
                                                      input logic [rgil_pkg::ENTRY_W-1:0] val);
        rgil_pkg::t_in_item it;
        it.func        = FUNC_TABLE_WRITE;
        it.blue_in     = rgil_pkg::COLOR_W'($urandom);
        it.green_in    = rgil_pkg::COLOR_W'($urandom);
        it.red_in      = rgil_pkg::COLOR_W'($urandom);
        it.entry_index = idx;
        it.entry_value = val;
        return it;
    endfunction

    // Colour biased towards zero, full scale and just past full scale.
    function automatic logic [rgil_pkg::COLOR_W-1:0] pick_color();
        int unsigned in_max;
        logic [rgil_pkg::COLOR_W-1:0] c;
        in_max = (1 << eff_bits(cfg_input_bits)) - 1;
        case ($urandom_range(0, 9))
            0: c = '0;
            1: c = rgil_pkg::COLOR_W'(in_max);
            2: c = rgil_pkg::COLOR_W'(in_max + 1);
            3: c = '1;
            4, 5, 6: c = rgil_pkg::COLOR_W'($urandom_range(0, in_max));
            default: c = rgil_pkg::COLOR_W'($urandom);
        endcase
        return c;
    endfunction

    // Curve point, mostly within 0..1.0 and sometimes above it.
    function automatic logic [rgil_pkg::ENTRY_W-1:0] pick_entry();
        logic [rgil_pkg::ENTRY_W-1:0] e;
        case ($urandom_range(0, 9))
            0: e = '0;
            1: e = rgil_pkg::ENTRY_W'(65536);
            2: e = rgil_pkg::ENTRY_W'($urandom_range(65537, 131071));
            default: e = rgil_pkg::ENTRY_W'($urandom_range(0, 65536));
        endcase
        return e;
    endfunction

    // Sends one transaction in bursts with random gaps and updates the prediction on acceptance.
    task automatic send_item(input rgil_pkg::t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (gaps_enabled) begin
                gap = $urandom_range(1, 15);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (item.func == FUNC_TABLE_WRITE) begin
            curve_pts[item.entry_index] = item.entry_value;
        end else begin
            pending_pixels.push_back(eval_pixel(item));
        end
    endtask

    // Holds the input quiet until every pixel has come out and the pipeline has emptied.
    task automatic settle_pipeline();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the channel is left valid for a following write.
    task automatic cfg_write(input rgil_pkg::t_cfg_reg sel,
                             input logic [rgil_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (sel)
            rgil_pkg::CFG_POINT_COUNT: cfg_point_count = data[rgil_pkg::PC_W-1:0];
            rgil_pkg::CFG_INPUT_BITS:  cfg_input_bits  = data[rgil_pkg::BITS_W-1:0];
            rgil_pkg::CFG_OUTPUT_BITS: cfg_output_bits = data[rgil_pkg::BITS_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all three registers once the unit is idle.
    task automatic apply_config(input logic [rgil_pkg::CFG_DATA_W-1:0] pc,
                                input logic [rgil_pkg::CFG_DATA_W-1:0] ib,
                                input logic [rgil_pkg::CFG_DATA_W-1:0] ob);
        settle_pipeline();
        cfg_write(rgil_pkg::CFG_POINT_COUNT, pc);
        cfg_write(rgil_pkg::CFG_INPUT_BITS, ib);
        cfg_write(rgil_pkg::CFG_OUTPUT_BITS, ob);
        i_cfg_valid <= 1'b0;
    endtask

    // Loads a square-law curve and checks a few pixels with the reset configuration.
    task automatic test_reset_defaults();
        longint val;
        for (int i = 0; i < rgil_pkg::CURVE_DEPTH; i++) begin
            val = (longint'(i) * i * 65536)
                / ((rgil_pkg::CURVE_DEPTH - 1) * (rgil_pkg::CURVE_DEPTH - 1));
            send_item(make_write(rgil_pkg::IDX_W'(i), rgil_pkg::ENTRY_W'(val)));
        end
        send_item(make_pixel(16'd0, 16'd4095, 16'hFFFF));
        send_item(make_pixel(16'd2048, 16'd1, 16'd4096));
        repeat (4) send_item(make_pixel(pick_color(), pick_color(), pick_color()));
    endtask

    // Smallest and largest settings, including out-of-range register values.
    task automatic test_corner_pixels();
        logic [rgil_pkg::CFG_DATA_W-1:0] pcs [5] = '{9'd2, 9'd256, 9'd0, 9'd511, 9'd257};
        logic [rgil_pkg::CFG_DATA_W-1:0] ibs [5] = '{9'd1, 9'd16, 9'd0, 9'd31, 9'd17};
        logic [rgil_pkg::CFG_DATA_W-1:0] obs [5] = '{9'd1, 9'd16, 9'd0, 9'd31, 9'd5};
        for (int k = 0; k < 5; k++) begin
            apply_config(pcs[k], ibs[k], obs[k]);
            send_item(make_pixel(16'd0, 16'hFFFF, 16'h5555));
            send_item(make_pixel(16'hFFFF, 16'h0000, 16'hAAAA));
            send_item(make_pixel(16'h8000, 16'h7FFF, 16'h0001));
        end
    endtask

    // Curve points above 1.0 must push the result into the output clip.
    task automatic test_curve_clipping();
        apply_config(9'd2, 9'd8, 9'd8);
        send_item(make_write(8'd0, 17'h1FFFF));
        send_item(make_write(8'd1, 17'h1FFFF));
        send_item(make_pixel(16'd0, 16'd255, 16'd128));
        apply_config(9'd256, 9'd12, 9'd16);
        send_item(make_write(8'd254, 17'h1FFFF));
        send_item(make_write(8'd255, 17'h10000));
        send_item(make_pixel(16'hFFFF, 16'd4094, 16'd0));
    endtask

    // Register value for a bit depth, sometimes with junk in the unused upper bits.
    function automatic logic [rgil_pkg::CFG_DATA_W-1:0] pick_bits();
        logic [rgil_pkg::CFG_DATA_W-1:0] d;
        logic [4:0] corner [5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
        if ($urandom_range(0, 4) == 0) d = rgil_pkg::CFG_DATA_W'(corner[$urandom_range(0, 4)]);
        else d = rgil_pkg::CFG_DATA_W'($urandom_range(1, 16));
        if ($urandom_range(0, 7) == 0) d[rgil_pkg::CFG_DATA_W-1:rgil_pkg::BITS_W] = 4'($urandom);
        return d;
    endfunction

    // Random configurations, each followed by a mixed stream of pixels and table writes.
    task automatic test_random_traffic();
        logic [rgil_pkg::CFG_DATA_W-1:0] pc_corner [8] = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd255,
                                                           9'd256, 9'd257, 9'd511};
        logic [rgil_pkg::CFG_DATA_W-1:0] pc;
        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 5))
                0: pc = pc_corner[$urandom_range(0, 7)];
                1: pc = rgil_pkg::CFG_DATA_W'($urandom_range(2, 8));
                2, 3: pc = rgil_pkg::CFG_DATA_W'($urandom_range(2, 256));
                4: pc = rgil_pkg::CFG_DATA_W'($urandom_range(0, 511));
                default: pc = 9'd256;
            endcase
            apply_config(pc, pick_bits(), pick_bits());
            gaps_enabled = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 125; k++) begin
                if ($urandom_range(0, 99) < 15) begin
                    send_item(make_write(rgil_pkg::IDX_W'($urandom), pick_entry()));
                end else begin
                    send_item(make_pixel(pick_color(), pick_color(), pick_color()));
                end
            end
        end
    endtask

    // Main sequence: reset once, then each test in turn.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_corner_pixels();
        test_curve_clipping();
        test_random_traffic();
        settle_pipeline();
        if (fault_count == 0) begin
            $display("rgb_gamma_interpolated_lut_unit verification clean");
        end else begin
            $display("rgb_gamma_interpolated_lut_unit verification failed");
        end
        $finish;
    end

    // Receiver stall pattern: free flow, light or heavy random stalls, or long stall runs.
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode_left = $urandom_range(50, 300);
            rx_mode = t_rx_mode'($urandom_range(0, 3));
        end
        rx_mode_left--;
        case (rx_mode)
            RX_FLOW:  i_stall <= 1'b0;
            RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_run_left == 0) begin
                    rx_run_left = $urandom_range(1, 20);
                    rx_run_stalled = !rx_run_stalled;
                end
                rx_run_left--;
                i_stall <= rx_run_stalled;
            end
        endcase
    end

    // Reports one field of a corrected pixel that differs from the prediction.
    task automatic compare_field(input string name, input logic [rgil_pkg::COLOR_W-1:0] want,
                                 input logic [rgil_pkg::COLOR_W-1:0] got);
        if (got !== want) begin
            fault_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Each output transaction is matched against the oldest predicted pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_pixels.size() == 0) begin
                fault_count++;
                $display("%0t ns: no pixel expected, got %h", $time, o_data);
            end else begin
                want_px = pending_pixels.pop_front();
                compare_field("blue_out", want_px.blue_out, o_data.blue_out);
                compare_field("green_out", want_px.green_out, o_data.green_out);
                compare_field("red_out", want_px.red_out, o_data.red_out);
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)
                    || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("rgb_gamma_interpolated_lut_unit verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rgil_pkg.sv
src/rgil_ram.sv
src/rgil_lane.sv
src/rgb_gamma_interpolated_lut_unit.sv
src/rgil_checker.sv
tb/tb.sv
